FILE: sv/luhn_card_number_check_top_assert.svh
// Assertion macros for the card number check block.
// Used by luhn_card_number_check_top; needs clk_i and rst_ni in scope.
`ifndef LUHN_CARD_NUMBER_CHECK_TOP_ASSERT_SVH
`define LUHN_CARD_NUMBER_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define LCNC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LCNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lcnc_pkg.sv
// Shared types and constants for the card number check block.
// No dependencies; used by lcnc_b2d and luhn_card_number_check_top.
package lcnc_pkg;

  localparam int NumberWidth = 64;                 // input bits used, 40..64
  localparam int CardWidth   = 64;                 // port width of card_number
  localparam int BcdDigits   = 20;                 // decimal digits of a 64-bit number
  localparam int BcdWidth    = BcdDigits * 4;
  localparam int BitCntW     = $clog2(NumberWidth);
  localparam int DigIdxW     = $clog2(BcdDigits);
  localparam int CountW      = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIGIT,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    BRAND_NONE   = 2'd0,
    BRAND_P34_37 = 2'd1,
    BRAND_P51_55 = 2'd2,
    BRAND_P4     = 2'd3
  } brand_e;

endpackage

FILE: sv/lcnc_b2d.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on lcnc_pkg.
module lcnc_b2d (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [lcnc_pkg::NumberWidth-1:0]    number_i,
  output logic                                done_o,
  output logic [lcnc_pkg::BcdWidth-1:0]       bcd_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [lcnc_pkg::BitCntW-1:0]       cnt_q, cnt_d;
  logic [lcnc_pkg::NumberWidth-1:0]   bin_q, bin_d;
  logic [lcnc_pkg::BcdWidth-1:0]      bcd_q, bcd_d;
  logic [lcnc_pkg::BcdWidth-1:0]      adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    adj = bcd_q;
    for (int i = 0; i < lcnc_pkg::BcdDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = lcnc_pkg::BitCntW'(lcnc_pkg::NumberWidth - 1);
      bin_d  = number_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bin_d = {bin_q[lcnc_pkg::NumberWidth-2:0], 1'b0};
      bcd_d = {adj[lcnc_pkg::BcdWidth-2:0], bin_q[lcnc_pkg::NumberWidth-1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

FILE: sv/luhn_card_number_check_top.sv
// Card number check: checks the mod-10 digit sum of a binary card number and
// classes its brand from digit count and leading digits.
// Usage:
//   Input channel in_valid_i/in_ready_o carries card_number_i, one word per
//   number; only the low NumberWidth bits are used.
//   Output channel out_valid_o/out_ready_i carries brand_o, checksum_ok_o and
//   digit_count_o, one word per input word.
//   Timing: one number at a time. After acceptance the number is converted to
//   decimal one bit per cycle, then its 20 decimal digits are scanned one per
//   cycle, then the FINISH state loads the result once the output register is
//   free; the block then returns to idle and takes the next number from there.
//   The bit-serial converter takes most of the time from input to output.
//   The result sits in an output register, so a new number is accepted while
//   the previous result still waits; if the receiver stalls past the end of
//   the next number's scan, the block holds that result and takes no input.
//   Reset clears the controller and the output valid; no clearing pass.
// Depends on lcnc_pkg, lcnc_b2d and luhn_card_number_check_top_assert.svh.
`include "luhn_card_number_check_top_assert.svh"

module luhn_card_number_check_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lcnc_pkg::CardWidth-1:0]     card_number_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         brand_o,
  output logic                               checksum_ok_o,
  output logic [lcnc_pkg::CountW-1:0]        digit_count_o
);

  lcnc_pkg::state_e                 state_q, state_d;
  logic                             conv_start;
  logic                             conv_done;
  logic [lcnc_pkg::BcdWidth-1:0]    conv_bcd;
  logic                             out_load;
  logic                             out_free;

  // digit scan registers
  logic [lcnc_pkg::BcdWidth-1:0]    dig_q;
  logic [lcnc_pkg::DigIdxW-1:0]     idx_q;
  logic [3:0]                       acc_q, acc_d;
  logic [lcnc_pkg::CountW-1:0]      cnt_q;
  logic [3:0]                       lead1_q;
  logic [3:0]                       lead_lo_q;
  logic [3:0]                       prev_q;
  logic                             last_dig;

  logic [3:0]                       cur;
  logic [4:0]                       dbl;
  logic [3:0]                       dval;
  logic [4:0]                       sum5;
  lcnc_pkg::brand_e                 brand_d;

  logic                             out_valid_q;
  logic [1:0]                       brand_q;
  logic                             ok_q;
  logic [lcnc_pkg::CountW-1:0]      count_q;

  lcnc_b2d u_b2d (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .number_i (card_number_i[lcnc_pkg::NumberWidth-1:0]),
    .done_o   (conv_done),
    .bcd_o    (conv_bcd)
  );

  assign last_dig = (idx_q == lcnc_pkg::DigIdxW'(lcnc_pkg::BcdDigits - 1));
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcnc_pkg::ST_IDLE:   if (in_valid_i) state_d = lcnc_pkg::ST_CONV;
      lcnc_pkg::ST_CONV:   if (conv_done) state_d = lcnc_pkg::ST_DIGIT;
      lcnc_pkg::ST_DIGIT:  if (last_dig) state_d = lcnc_pkg::ST_FINISH;
      lcnc_pkg::ST_FINISH: if (out_free) state_d = lcnc_pkg::ST_IDLE;
      default:             state_d = lcnc_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o = 1'b0;
    conv_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      lcnc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        conv_start = in_valid_i;
      end
      lcnc_pkg::ST_FINISH: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcnc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // one digit of the Luhn sum per cycle, least significant first
  always_comb begin
    cur  = dig_q[3:0];
    dbl  = {cur, 1'b0};
    dval = cur;
    if (idx_q[0]) begin
      dval = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
    end
    sum5  = {1'b0, acc_q} + {1'b0, dval};
    acc_d = (sum5 >= 5'd10) ? 4'(sum5 - 5'd10) : sum5[3:0];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == lcnc_pkg::ST_CONV && conv_done) begin
      dig_q     <= conv_bcd;
      idx_q     <= '0;
      acc_q     <= '0;
      cnt_q     <= '0;
      lead1_q   <= '0;
      lead_lo_q <= '0;
      prev_q    <= '0;
    end else if (state_q == lcnc_pkg::ST_DIGIT) begin
      dig_q  <= {4'd0, dig_q[lcnc_pkg::BcdWidth-1:4]};
      idx_q  <= idx_q + 1'b1;
      acc_q  <= acc_d;
      prev_q <= cur;
      if (cur != 4'd0) begin
        // highest non-zero digit so far sets count and leading pair
        cnt_q     <= lcnc_pkg::CountW'(idx_q) + 1'b1;
        lead1_q   <= cur;
        lead_lo_q <= prev_q;
      end
    end
  end

  always_comb begin
    brand_d = lcnc_pkg::BRAND_NONE;
    if (acc_q == 4'd0) begin
      if (cnt_q == 5'd15 && lead1_q == 4'd3 && (lead_lo_q == 4'd4 || lead_lo_q == 4'd7)) begin
        brand_d = lcnc_pkg::BRAND_P34_37;
      end else if (cnt_q == 5'd16 && lead1_q == 4'd5 && lead_lo_q >= 4'd1
                   && lead_lo_q <= 4'd5) begin
        brand_d = lcnc_pkg::BRAND_P51_55;
      end else if ((cnt_q == 5'd16 || cnt_q == 5'd13) && lead1_q == 4'd4) begin
        brand_d = lcnc_pkg::BRAND_P4;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      brand_q <= brand_d;
      ok_q    <= (acc_q == 4'd0);
      count_q <= cnt_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign brand_o       = brand_q;
  assign checksum_ok_o = ok_q;
  assign digit_count_o = count_q;

  `LCNC_ASSERT_SAME(a_done_in_conv, conv_done, state_q == lcnc_pkg::ST_CONV,
                    "conversion finished outside CONV")
  `LCNC_ASSERT_NEXT(a_scan_ends, state_q == lcnc_pkg::ST_DIGIT && last_dig,
                    state_q == lcnc_pkg::ST_FINISH, "digit scan overran")
  `LCNC_ASSERT_SAME(a_brand_needs_ok, out_valid_o && brand_o != lcnc_pkg::BRAND_NONE,
                    checksum_ok_o, "brand given with failed checksum")
  `LCNC_ASSERT_SAME(a_p34_count, out_valid_o && brand_o == lcnc_pkg::BRAND_P34_37,
                    digit_count_o == 5'd15, "fifteen-digit brand with wrong count")
  `LCNC_ASSERT_NEXT(a_load_sets_valid, out_load, out_valid_o, "result load lost")

endmodule
